>>> hdl/osa_pkg.sv
// Shared types and codes for the owner-tagged slot allocator.
package osa_pkg;

  localparam int ACTION_W = 2;
  localparam int USER_W   = 8;
  localparam int SLOT_W   = 5;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd5;

  localparam logic [ACTION_W-1:0] ACT_FIRST   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_NAMED   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_REFUSED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_OWNER,
    ST_FIN
  } osa_state_t;

endpackage

>>> hdl/osa_if.sv
// Handshake channels of the slot allocator: request, result and configuration.
interface osa_in_if import osa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [USER_W-1:0]   user_id;
  logic [SLOT_W-1:0]   slot_number;
  modport source (output valid, action, user_id, slot_number, input ready);
  modport sink   (input valid, action, user_id, slot_number, output ready);
endinterface

interface osa_out_if import osa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_number_res;
  modport source (output valid, status, slot_number_res, input ready);
  modport sink   (input valid, status, slot_number_res, output ready);
endinterface

interface osa_cfg_if import osa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> hdl/osa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module osa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/owner_tagged_slot_allocator_top.sv
// Top level of the owner-tagged slot allocator.
//
// Channels: in_ch takes request words (action, user_id, slot_number);
// out_ch returns one result word (status, slot_number_res) per request;
// cfg_ch writes slots_in_use and is always ready. Write it only when idle.
// Every channel moves a word at a clock edge where valid and ready are high.
//
// Timing: one request at a time. Reserve-first walks the reserved flags one
// slot per cycle, from slot 1 until it finds a free one or passes the last
// active slot. Reserve-named checks its slot in the CHECK state; release adds
// an OWNER state for the owner RAM read. in_ch.ready is high only while the
// sequencer is idle.
//
// The result sits in an output register: a new request is taken while it
// waits, and the sequencer holds in its final step until out_ch drains.
//
// Reset (rst_n low, synchronous) frees every slot, clears the sequencer and
// the output valid flag, and sets slots_in_use to 5.
module owner_tagged_slot_allocator_top import osa_pkg::*; #(
  parameter int NUM_SLOTS = 16,
  parameter int USER_BITS = 8
) (
  input logic       clk,
  input logic       rst_n,
  osa_in_if.sink    in_ch,
  osa_out_if.source out_ch,
  osa_cfg_if.sink   cfg_ch
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  osa_state_t state_r, state_nxt;

  logic [CFG_W-1:0]     cfg_r;
  logic [NUM_SLOTS-1:0] rsv_r;
  logic [ACTION_W-1:0]  act_r, act_nxt;
  logic [USER_BITS-1:0] user_r, user_nxt;
  logic [SLOT_W-1:0]    k_r, k_nxt;
  logic [STATUS_W-1:0]  stat_r, stat_nxt;
  logic [SLOT_W-1:0]    res_r, res_nxt;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_stat_r;
  logic [SLOT_W-1:0]    out_res_r;

  logic [SLOT_W-1:0]    count;
  logic [IDX_W-1:0]     idx;
  logic                 k_in_range;
  logic                 rsv_bit;
  logic                 slot_free;
  logic [USER_BITS-1:0] owner_rd;
  logic [USER_BITS-1:0] owner_eff;
  logic                 in_acc;
  logic                 out_load;
  logic                 rsv_set;
  logic                 rsv_clr;

  // clamp active count to the table size
  always_comb begin
    if ({4'b0, cfg_r} > 9'(NUM_SLOTS)) begin
      count = SLOT_W'(NUM_SLOTS);
    end else begin
      count = cfg_r;
    end
  end

  assign idx        = IDX_W'(k_r - SLOT_W'(1));
  assign k_in_range = (k_r != '0) && (k_r <= count);
  assign rsv_bit    = (32'(idx) < NUM_SLOTS) ? rsv_r[idx] : 1'b1;
  assign slot_free  = !rsv_bit;
  assign owner_eff  = rsv_bit ? owner_rd : '0;
  assign in_acc     = in_ch.valid && in_ch.ready;
  assign out_load   = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_stat_r;
  assign out_ch.slot_number_res = out_res_r;

  osa_ram #(
    .WIDTH (USER_BITS),
    .DEPTH (NUM_SLOTS)
  ) u_owner_ram (
    .clk   (clk),
    .we    (rsv_set),
    .waddr (idx),
    .wdata (user_r),
    .raddr (idx),
    .rdata (owner_rd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.action)
            ACT_FIRST:               state_nxt = ST_SCAN;
            ACT_NAMED, ACT_RELEASE:  state_nxt = ST_CHECK;
            default:                 state_nxt = ST_FIN;
          endcase
        end
      end
      ST_SCAN: begin
        if (!k_in_range || slot_free) begin
          state_nxt = ST_FIN;
        end
      end
      ST_CHECK: begin
        if (!k_in_range || act_r == ACT_NAMED) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_OWNER;
        end
      end
      ST_OWNER: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    act_nxt  = act_r;
    user_nxt = user_r;
    k_nxt    = k_r;
    stat_nxt = stat_r;
    res_nxt  = res_r;
    rsv_set  = 1'b0;
    rsv_clr  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          act_nxt  = in_ch.action;
          user_nxt = USER_BITS'(in_ch.user_id);
          k_nxt    = (in_ch.action == ACT_FIRST) ? SLOT_W'(1) : in_ch.slot_number;
          stat_nxt = STAT_REFUSED;
          res_nxt  = '0;
        end
      end
      ST_SCAN: begin
        if (k_in_range) begin
          if (slot_free) begin
            rsv_set  = 1'b1;
            stat_nxt = STAT_DONE;
            res_nxt  = k_r;
          end else begin
            k_nxt = k_r + SLOT_W'(1);
          end
        end
      end
      ST_CHECK: begin
        res_nxt = k_r;
        if (!k_in_range) begin
          stat_nxt = STAT_RANGE;
        end else if (act_r == ACT_NAMED && slot_free) begin
          rsv_set  = 1'b1;
          stat_nxt = STAT_DONE;
        end
      end
      ST_OWNER: begin
        if (owner_eff == user_r) begin
          rsv_clr  = 1'b1;
          stat_nxt = STAT_DONE;
        end
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= CFG_RESET;
      rsv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        cfg_r <= cfg_ch.data;
      end
      if (rsv_set) begin
        rsv_r[idx] <= 1'b1;
      end else if (rsv_clr) begin
        rsv_r[idx] <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    user_r <= user_nxt;
    k_r    <= k_nxt;
    stat_r <= stat_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_stat_r <= stat_r;
      out_res_r  <= res_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE)
    else $error("sequencer idle right after accepting a request");

  a_done_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stat_r == STAT_DONE |-> out_res_r != '0)
    else $error("completed request reports no slot");

  a_range_is_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stat_r == STAT_RANGE |-> out_res_r == '0 || out_res_r > count)
    else $error("range error on an active slot");

  a_one_flag_per_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> $countones(rsv_r) <= $countones($past(rsv_r)) + 1)
    else $error("more than one slot reserved in a cycle");
`endif

endmodule
